// ===== hdl/llns_pkg.sv =====
// ----------------------------------------------------------------------------
// llns_pkg: shared types and constants of the least loaded live node selector
// Holds the field widths, the register indexes, the report and scan token
// structs, and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package llns_pkg;

    // field widths
    localparam int NODE_W  = 7;
    localparam int BEST_W  = 6;
    localparam int LOAD_W  = 17;
    localparam int TIME_W  = 64;
    localparam int LIMIT_W = 36;
    localparam int IDX8_W  = 8;

    // default table depth
    localparam int NODE_COUNT_DEF = 64;

    // load of 1.0 in unsigned Q1.16
    localparam logic [LOAD_W-1:0] LOAD_ONE = 17'd65536;

    // configuration register indexes and reset values
    localparam logic CFG_LOCAL_NODE  = 1'b0;
    localparam logic CFG_STALE_LIMIT = 1'b1;
    localparam logic [BEST_W-1:0]  LOCAL_NODE_RST = 6'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = 36'd17000000000;

    // item kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // load report broadcast to every cell
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic [LOAD_W-1:0] load;
        logic [TIME_W-1:0] now;
    } t_report;

    // select token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] now;
        logic [BEST_W-1:0] sel_node;
        logic [LOAD_W-1:0] sel_load;
    } t_token;

endpackage

// ===== hdl/llns_cell.sv =====
// ----------------------------------------------------------------------------
// llns_cell: one node entry of the selector chain
// Stores one node's load and last-heard time, and updates the passing select
// token when this node is live and lighter than the best seen so far.
// ----------------------------------------------------------------------------
module llns_cell
    import llns_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_report            i_report,
    input  logic [LIMIT_W-1:0] i_limit,
    input  t_token             i_tok,
    output t_token             o_tok
);

    logic [LOAD_W-1:0] r_load;
    logic [TIME_W-1:0] r_heard;
    t_token            r_tok;
    t_token            n_tok;
    logic [TIME_W-1:0] w_age;
    logic              w_live;
    logic              w_hit;

    // report addressed to this entry
    assign w_hit = i_report.valid && ({1'b0, i_report.node} == IDX8_W'(CELL_IDX));

    // wrapping age and liveness
    assign w_age  = i_tok.now - r_heard;
    assign w_live = w_age < TIME_W'(i_limit);

    // candidate update, strict compare keeps the lower index on ties
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && w_live && (r_load < i_tok.sel_load)) begin
            n_tok.sel_node = BEST_W'(CELL_IDX);
            n_tok.sel_load = r_load;
        end
    end

    // entry storage and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_heard <= '0;
            r_tok   <= '0;
        end else begin
            if (w_hit) begin
                r_load  <= i_report.load;
                r_heard <= i_report.now;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/least_loaded_live_node_selector.sv =====
// ----------------------------------------------------------------------------
// least_loaded_live_node_selector: least loaded live node picker
// Chain of node cells holding load and last-heard time per node, scanned by a
// select token that moves one cell per cycle.
// ----------------------------------------------------------------------------
// A load report is written straight into its node's cell when it is taken;
// reports for node numbers at or above NODE_COUNT are dropped. A select
// enters a token carrying the local node at load 1.0 into cell 0, and the
// token moves one cell per clock through the chain walk, then passes the
// hold stage and the output register; the next item is taken only after
// the result has left the hold stage.
// While a select is in flight no new item is taken; a result waiting in the
// output register does not block the next item, one held behind it in the
// hold stage does. Reset clears all entries at once, with no clearing pass.
// Configuration writes are always accepted.
module least_loaded_live_node_selector
    import llns_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [87:0]        i_s_axis_tdata,   // node_id[6:0], load[23:7], now[87:24]
    input  logic               i_s_axis_tuser,   // kind[0]
    // result stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // sel_node[5:0], sel_load[22:6], zero pad
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic [BEST_W-1:0]  r_local_node;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_busy;
    logic               r_pend_valid;
    logic [BEST_W-1:0]  r_pend_node;
    logic [LOAD_W-1:0]  r_pend_load;
    logic               r_out_valid;
    logic [BEST_W-1:0]  r_out_node;
    logic [LOAD_W-1:0]  r_out_load;

    logic               w_in_acc;
    logic               w_sel;
    logic               w_out_free;
    logic [NODE_W-1:0]  w_node;
    logic [LOAD_W-1:0]  w_load;
    logic [TIME_W-1:0]  w_now;
    t_report            w_report;
    t_token             w_head_tok;
    t_token             w_tok [NODE_COUNT+1];
    logic [NODE_COUNT:1] w_tok_valid;

    // field unpacking
    assign w_node = i_s_axis_tdata[6:0];
    assign w_load = i_s_axis_tdata[23:7];
    assign w_now  = i_s_axis_tdata[87:24];

    assign o_s_axis_tready = !r_busy;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sel           = w_in_acc && (i_s_axis_tuser == KIND_SELECT);

    // report broadcast with saturation to 1.0
    always_comb begin
        w_report.valid = w_in_acc && (i_s_axis_tuser == KIND_REPORT);
        w_report.node  = w_node;
        w_report.load  = (w_load > LOAD_ONE) ? LOAD_ONE : w_load;
        w_report.now   = w_now;
    end

    // token injected at the chain head
    always_comb begin
        w_head_tok.valid    = w_sel;
        w_head_tok.now      = w_now;
        w_head_tok.sel_node = r_local_node;
        w_head_tok.sel_load = LOAD_ONE;
    end

    assign w_tok[0] = w_head_tok;

    // cell chain
    for (genvar g = 0; g < NODE_COUNT; g++) begin : g_cell
        llns_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_report (w_report),
            .i_limit  (r_limit),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    for (genvar g = 1; g <= NODE_COUNT; g++) begin : g_tv
        assign w_tok_valid[g] = w_tok[g].valid;
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_node <= LOCAL_NODE_RST;
            r_limit      <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCAL_NODE:  r_local_node <= i_cfg_data[BEST_W-1:0];
                CFG_STALE_LIMIT: r_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold stage and output register
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_sel) begin
                r_busy <= 1'b1;
            end
            if (w_tok[NODE_COUNT].valid) begin
                r_pend_valid <= 1'b1;
            end
            if (r_pend_valid && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
                r_busy       <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[NODE_COUNT].valid) begin
            r_pend_node <= w_tok[NODE_COUNT].sel_node;
            r_pend_load <= w_tok[NODE_COUNT].sel_load;
        end
        if (r_pend_valid && w_out_free) begin
            r_out_node <= r_pend_node;
            r_out_load <= r_pend_load;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_load, r_out_node};

    // checks
    a_sel_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sel |=> r_busy)
        else $error("select accepted without entering busy");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("held result while not busy");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_valid[NODE_COUNT:1], r_pend_valid}))
        else $error("more than one select in flight");

    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[NODE_COUNT].valid |-> r_busy)
        else $error("token left the chain while not busy");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_load <= LOAD_ONE))
        else $error("result load above 1.0");

endmodule

// ===== verif/tb_least_loaded_live_node_selector.sv =====
// ----------------------------------------------------------------------------
// tb_least_loaded_live_node_selector: self-checking bench of the node selector
// Drives load reports and selects into the input stream and writes the two
// configuration registers while the block is idle. A shadow copy of the load
// and last-heard tables predicts every select answer, and a monitor compares
// each result transaction with the oldest prediction. Directed cases come
// first, then random traffic under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_least_loaded_live_node_selector;
    import llns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_LATENCY = NODE_COUNT_DEF + 2;
    localparam int SETTLE_CYCLES = SCAN_LATENCY + 10;
    localparam int STALL_LIMIT = 5000;
    localparam int CHUNK_ITEMS = 100;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef struct packed {
        logic [BEST_W-1:0] node;
        logic [LOAD_W-1:0] load;
    } t_pick;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               o_s_axis_tready;
    logic [87:0]        s_data = '0;
    logic               s_user = 1'b0;
    logic               o_m_axis_tvalid;
    logic               m_ready = 1'b0;
    logic [23:0]        o_m_axis_tdata;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               cfg_index = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;

    // shadow state of the block
    logic [LOAD_W-1:0]  load_shadow [NODE_COUNT_DEF];
    logic [TIME_W-1:0]  heard_shadow [NODE_COUNT_DEF];
    logic [BEST_W-1:0]  local_shadow;
    logic [LIMIT_W-1:0] limit_shadow;
    t_pick              pending_picks [$];

    // traffic shaping
    int                 src_idle_pct = 0;
    int                 sink_idle_pct = 0;
    int                 sink_hold_len = 0;
    int                 sink_hold_reqs = 0;
    int                 sink_hold_seen = 0;
    int                 sink_hold_left = 0;
    int                 fail_count = 0;
    int                 quiet_cycles = 0;
    logic [TIME_W-1:0]  tick;

    least_loaded_live_node_selector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),      // node_id[6:0], load[23:7], now[87:24]
        .i_s_axis_tuser  (s_user),      // kind[0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // sel_node[5:0], sel_load[22:6], pad
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // least loaded live node among the shadow entries, else the local node
    function automatic t_pick least_loaded_pick(input logic [TIME_W-1:0] stamp);
        t_pick             best;
        logic [TIME_W-1:0] age;
        best.node = local_shadow;
        best.load = LOAD_ONE;
        for (int i = 0; i < NODE_COUNT_DEF; i++) begin
            age = stamp - heard_shadow[i];
            if (age < {28'd0, limit_shadow} && load_shadow[i] < best.load) begin
                best.load = load_shadow[i];
                best.node = i[BEST_W-1:0];
            end
        end
        return best;
    endfunction

    task automatic clear_shadow();
        for (int i = 0; i < NODE_COUNT_DEF; i++) begin
            load_shadow[i] = '0;
            heard_shadow[i] = '0;
        end
        local_shadow = LOCAL_NODE_RST;
        limit_shadow = LIMIT_RST;
    endtask

    // one input transaction, with an idle gap in front of a random length
    task automatic send_item(input logic kind, input logic [NODE_W-1:0] node,
                             input logic [LOAD_W-1:0] load,
                             input logic [TIME_W-1:0] stamp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {stamp, load, node};
        do @(posedge i_clk); while (!o_s_axis_tready);
        // update the shadow tables or queue the expected answer
        if (kind == KIND_REPORT) begin
            if (node < NODE_COUNT_DEF) begin
                load_shadow[node[5:0]]  = (load > LOAD_ONE) ? LOAD_ONE : load;
                heard_shadow[node[5:0]] = stamp;
            end
        end else begin
            pending_picks.push_back(least_loaded_pick(stamp));
        end
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic index, input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_LOCAL_NODE)
            local_shadow = value[BEST_W-1:0];
        else
            limit_shadow = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every answer, then let the scan chain empty
    task automatic drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random register settings, extremes included
    task automatic random_setup();
        logic [LIMIT_W-1:0] lim;
        case ($urandom_range(0, 7))
            0: lim = '0;
            1: lim = LIMIT_MAX;
            2: lim = 36'd5000;
            3: lim = 36'd3400;
            4: lim = 36'd1000;
            5: lim = LIMIT_RST;
            default: lim = LIMIT_W'({$urandom, $urandom});
        endcase
        write_reg(CFG_LOCAL_NODE, LIMIT_W'({$urandom, $urandom}));
        write_reg(CFG_STALE_LIMIT, lim);
    endtask

    // one random report or select on a slowly advancing time line
    task automatic random_item();
        logic [TIME_W-1:0]  stamp;
        logic [NODE_W-1:0]  node;
        logic [LOAD_W-1:0]  load;
        logic               kind;
        int                 pick;
        tick = tick + ({$urandom, $urandom} % ({28'd0, limit_shadow >> 3} + 64'd2));
        if ($urandom_range(99) < 3)
            tick = {$urandom, $urandom};
        stamp = ($urandom_range(99) < 8) ? {$urandom, $urandom} : tick;
        kind = ($urandom_range(99) < 30) ? KIND_SELECT : KIND_REPORT;
        node = ($urandom_range(99) < 90) ? NODE_W'($urandom_range(0, 63))
                                         : NODE_W'($urandom_range(64, 127));
        pick = $urandom_range(99);
        if (pick < 45)
            load = LOAD_W'($urandom_range(0, 65536));
        else if (pick < 75) begin
            // a few repeated values so that ties happen often
            case ($urandom_range(0, 4))
                0: load = '0;
                1: load = 17'd100;
                2: load = 17'd65535;
                3: load = LOAD_ONE;
                default: load = 17'd3400;
            endcase
        end else if (pick < 90)
            load = LOAD_W'($urandom_range(65537, 131071));
        else
            load = LOAD_W'($urandom);
        send_item(kind, node, load, stamp);
    endtask

    // cleared tables: never-reported entries win while young enough
    task automatic test_cleared_tables();
        send_item(KIND_SELECT, '0, '0, '0);
        send_item(KIND_SELECT, 7'd127, '1, {28'd0, LIMIT_RST} - 64'd1);
        send_item(KIND_SELECT, '0, '0, {28'd0, LIMIT_RST});
        send_item(KIND_SELECT, '0, '0, '1);
        drain();
    endtask

    // saturation, dropped node numbers, ties, age right at the limit, wrap
    task automatic test_report_cases();
        logic [TIME_W-1:0] t0;
        t0 = 64'hFFFF_FFFF_FFFF_FE00;
        write_reg(CFG_LOCAL_NODE, 36'd63);
        write_reg(CFG_STALE_LIMIT, 36'd1000);
        send_item(KIND_REPORT, 7'd3, 17'd100, t0);
        send_item(KIND_REPORT, 7'd7, 17'd100, t0);
        send_item(KIND_REPORT, 7'd1, 17'd50, t0 - 64'd600);
        send_item(KIND_REPORT, 7'd64, 17'd0, t0);
        send_item(KIND_REPORT, 7'd127, 17'd0, t0);
        send_item(KIND_REPORT, 7'd5, 17'd131071, t0);
        send_item(KIND_REPORT, 7'd9, 17'd65537, t0);
        send_item(KIND_SELECT, '0, '0, t0 + 64'd399);
        send_item(KIND_SELECT, '0, '0, t0 + 64'd400);
        send_item(KIND_REPORT, 7'd3, LOAD_ONE, t0 + 64'd400);
        send_item(KIND_SELECT, '0, '0, t0 + 64'd500);
        send_item(KIND_SELECT, '0, '0, t0 + 64'd1500);
        drain();
    endtask

    // zero limit and widest limit
    task automatic test_limit_extremes();
        write_reg(CFG_STALE_LIMIT, '0);
        send_item(KIND_SELECT, '0, '0, 64'hFFFF_FFFF_FFFF_FF90);
        drain();
        write_reg(CFG_STALE_LIMIT, LIMIT_MAX);
        send_item(KIND_REPORT, 7'd0, 17'd65535, '0);
        send_item(KIND_SELECT, '0, '0, {28'd0, LIMIT_MAX} - 64'd1);
        send_item(KIND_SELECT, '0, '0, {28'd0, LIMIT_MAX});
        drain();
    endtask

    // random traffic in chunks, a new register setting before each chunk
    task automatic test_random_traffic(input int items, input int src_pct,
                                       input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < items; n++) begin
            if (n % CHUNK_ITEMS == 0) begin
                drain();
                random_setup();
            end
            random_item();
        end
        drain();
    endtask

    // long output stall while items keep coming, so the input backs up
    task automatic test_backpressure();
        src_idle_pct = 0;
        write_reg(CFG_STALE_LIMIT, LIMIT_RST);
        sink_hold_len = 300;
        sink_hold_reqs++;
        // selects first, so that output and hold stage fill during the stall
        for (int n = 0; n < 3; n++)
            send_item(KIND_SELECT, '0, '0, tick);
        for (int n = 0; n < 16; n++)
            random_item();
        drain();
    endtask

    // result receiver: random idling plus requested long holds
    always @(negedge i_clk) begin
        if (sink_hold_reqs != sink_hold_seen) begin
            sink_hold_seen = sink_hold_reqs;
            sink_hold_left = sink_hold_len;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pick want;
        t_pick got;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.node = o_m_axis_tdata[5:0];
            got.load = o_m_axis_tdata[22:6];
            if (pending_picks.size() == 0) begin
                $error("result with nothing expected: sel_node=%0d sel_load=%0d",
                       got.node, got.load);
                fail_count++;
            end else begin
                want = pending_picks.pop_front();
                if (got.node !== want.node) begin
                    $error("sel_node mismatch: expected %0d, got %0d",
                           want.node, got.node);
                    fail_count++;
                end
                if (got.load !== want.load) begin
                    $error("sel_load mismatch: expected %0d, got %0d",
                           want.load, got.load);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // test sequence
    initial begin
        clear_shadow();
        tick = {$urandom, $urandom};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_tables();
        test_report_cases();
        test_limit_extremes();
        test_random_traffic(400, 38, 48);
        test_random_traffic(400, 48, 38);
        test_backpressure();
        test_random_traffic(400, 0, 0);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
